/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SAW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAW_ASSERT(lbl, clk, rst_n, prop, msg)
`define SAW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/sawa_pkg.sv */
// Types and constants of the stop-and-wait ARQ endpoint.
package sawa_pkg;

  localparam int TIMER_WIDTH = 32;
  localparam int CMP_W       = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
  localparam int PORT_W      = 16;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 40;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [31:0]       TIMEOUT_RESET  = 32'd1000;
  localparam logic [PORT_W-1:0] MASK_RESET     = 16'd0;
  localparam logic [PORT_W-1:0] FALLBACK_RESET = 16'd5012;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RX   = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_SENT      = 3'd0,
    EV_RESENT    = 3'd1,
    EV_ACK_SENT  = 3'd2,
    EV_DELIVER   = 3'd3,
    EV_REFUSED   = 3'd4,
    EV_ACK_TAKEN = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_MASK     = 2'd1,
    REG_FALLBACK = 2'd2
  } reg_e;

  typedef struct packed {
    event_e            ev;
    logic [PORT_W-1:0] tx;
    logic [PORT_W-1:0] peer;
    logic              seq;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic        en;
    logic [1:0]  idx;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

/* sv/sawa_front.sv */
// Front end: configuration registers, protocol state and result classification.
module sawa_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sawa_pkg::cfg_wr_t        cfg_i,
  input  logic                     valid_i,
  input  logic                     accept_i,
  input  sawa_pkg::kind_e          kind_i,
  input  logic [sawa_pkg::PORT_W-1:0] own_port_i,
  input  logic [sawa_pkg::PORT_W-1:0] rx_port_i,
  output logic                     push_o,
  output sawa_pkg::entry_t         entry_o
);

  logic [31:0]                      timeout_q;
  logic [sawa_pkg::PORT_W-1:0]      mask_q, fallback_q;
  logic                             awaiting_q, awaiting_d;
  logic                             nss_q, nss_d;
  logic                             exp_q, exp_d;
  logic [sawa_pkg::PORT_W-1:0]      saved_q, saved_d;
  logic                             running_q, running_d;
  logic [sawa_pkg::TIMER_WIDTH-1:0] count_q, count_d;
  logic [sawa_pkg::TIMER_WIDTH-1:0] count_inc;
  logic [sawa_pkg::PORT_W-1:0]      port_sel, peer;
  logic                             rx_ack, rx_seq;
  logic                             fire;

  assign fire      = valid_i && accept_i;
  assign rx_ack    = rx_port_i[0];
  assign rx_seq    = rx_port_i[1];
  assign peer      = {rx_port_i[sawa_pkg::PORT_W-1:2], 2'b00};
  assign port_sel  = ((own_port_i & mask_q) != '0) ? fallback_q : own_port_i;
  assign count_inc = (count_q != '1) ? count_q + 1'b1 : count_q;

  always_comb begin
    awaiting_d = awaiting_q;
    nss_d      = nss_q;
    exp_d      = exp_q;
    saved_d    = saved_q;
    running_d  = running_q;
    count_d    = count_q;
    push_o     = 1'b0;
    entry_o    = '0;
    if (fire) begin
      unique case (kind_i)
        sawa_pkg::KIND_SEND: begin
          push_o = 1'b1;
          if (awaiting_q) begin
            entry_o.r0.ev  = sawa_pkg::EV_REFUSED;
            entry_o.r0.seq = ~nss_q;
          end else begin
            entry_o.r0.ev  = sawa_pkg::EV_SENT;
            entry_o.r0.tx  = port_sel + {14'd0, nss_q, 1'b0};
            entry_o.r0.seq = nss_q;
            saved_d    = port_sel;
            nss_d      = ~nss_q;
            awaiting_d = 1'b1;
            running_d  = 1'b1;
            count_d    = '0;
          end
        end
        sawa_pkg::KIND_RX: begin
          if (rx_ack) begin
            if (rx_seq == ~nss_q) begin
              push_o          = 1'b1;
              entry_o.r0.ev   = sawa_pkg::EV_ACK_TAKEN;
              entry_o.r0.peer = peer;
              entry_o.r0.seq  = rx_seq;
              awaiting_d = 1'b0;
              running_d  = 1'b0;
              count_d    = '0;
            end
          end else begin
            push_o = 1'b1;
            if (rx_seq == exp_q) begin
              exp_d           = ~rx_seq;
              entry_o.two     = 1'b1;
              entry_o.r0.ev   = sawa_pkg::EV_DELIVER;
              entry_o.r0.peer = peer;
              entry_o.r0.seq  = rx_seq;
              entry_o.r1.ev   = sawa_pkg::EV_ACK_SENT;
              entry_o.r1.tx   = own_port_i + {14'd0, rx_seq, 1'b1};
              entry_o.r1.peer = peer;
              entry_o.r1.seq  = rx_seq;
            end else begin
              entry_o.r0.ev   = sawa_pkg::EV_ACK_SENT;
              entry_o.r0.tx   = own_port_i + {14'd0, rx_seq, 1'b1};
              entry_o.r0.peer = peer;
              entry_o.r0.seq  = rx_seq;
            end
          end
        end
        sawa_pkg::KIND_TICK: begin
          if (running_q) begin
            if (sawa_pkg::CMP_W'(count_inc) >= sawa_pkg::CMP_W'(timeout_q)) begin
              count_d        = '0;
              push_o         = 1'b1;
              entry_o.r0.ev  = sawa_pkg::EV_RESENT;
              entry_o.r0.tx  = saved_q + {14'd0, ~nss_q, 1'b0};
              entry_o.r0.seq = ~nss_q;
            end else begin
              count_d = count_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= sawa_pkg::TIMEOUT_RESET;
      mask_q     <= sawa_pkg::MASK_RESET;
      fallback_q <= sawa_pkg::FALLBACK_RESET;
      awaiting_q <= 1'b0;
      nss_q      <= 1'b0;
      exp_q      <= 1'b0;
      saved_q    <= '0;
      running_q  <= 1'b0;
      count_q    <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      nss_q      <= nss_d;
      exp_q      <= exp_d;
      saved_q    <= saved_d;
      running_q  <= running_d;
      count_q    <= count_d;
      if (cfg_i.en) begin
        unique case (cfg_i.idx)
          sawa_pkg::REG_TIMEOUT:  timeout_q  <= cfg_i.data;
          sawa_pkg::REG_MASK:     mask_q     <= cfg_i.data[sawa_pkg::PORT_W-1:0];
          sawa_pkg::REG_FALLBACK: fallback_q <= cfg_i.data[sawa_pkg::PORT_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/sawa_queue.sv */
// Small result queue between the front end and the output stage.
module sawa_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  sawa_pkg::entry_t            entry_i,
  input  logic                        pop_i,
  output sawa_pkg::entry_t            head_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [sawa_pkg::QCNT_W-1:0] count_o
);

  sawa_pkg::entry_t                  mem_q [sawa_pkg::QDEPTH];
  logic [sawa_pkg::QPTR_W-1:0]       wptr_q, rptr_q;
  logic [sawa_pkg::QCNT_W-1:0]       cnt_q;
  logic                              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == sawa_pkg::QCNT_W'(sawa_pkg::QDEPTH));
  assign count_o = cnt_q;
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* sv/sawa_back.sv */
// Output stage: splits queued entries into result words with last marking.
module sawa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sawa_pkg::entry_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  input  logic             ready_i,
  output logic             valid_o,
  output sawa_pkg::res_t   res_o,
  output logic             last_o,
  output logic             sec_pending_o
);

  logic             valid_q;
  sawa_pkg::res_t   res_q;
  logic             last_q;
  logic             sec_valid_q;
  sawa_pkg::res_t   sec_q;
  logic             load;

  assign load          = !valid_q || ready_i;
  assign pop_o         = load && !sec_valid_q && !empty_i;
  assign valid_o       = valid_q;
  assign res_o         = res_q;
  assign last_o        = last_q;
  assign sec_pending_o = sec_valid_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        res_q  <= sec_q;
        last_q <= 1'b1;
      end else begin
        res_q  <= head_i.r0;
        last_q <= !head_i.two;
        sec_q  <= head_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        valid_q     <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        valid_q     <= !empty_i;
        sec_valid_q <= !empty_i && head_i.two;
      end
    end
  end

endmodule

/* sv/stop_and_wait_arq_endpoint.sv */
// Top level of the stop-and-wait ARQ endpoint.
// Accepts one event word per cycle while the 4-entry result queue has room;
// the front end updates the protocol state and timer in the cycle the word is
// taken. Results leave one word per cycle from the output register while the
// receiver is ready, so an event that yields two results (deliver plus ack)
// leaves as two words. Each result passes the queue and then the output register.
// Config writes are always ready and take effect on the next cycle.
`include "assert_macros.svh"

module stop_and_wait_arq_endpoint (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] own_port, [31:16] rx_port
  input  logic [sawa_pkg::TDATA_IN_W-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] tx_port, [31:16] peer_port, [32] seq_bit, [39:33] zero
  output logic [sawa_pkg::TDATA_OUT_W-1:0] m_axis_tdata_o,
  // [2:0] event_res
  output logic [2:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  sawa_pkg::cfg_wr_t                 cfg;
  logic                              q_push, q_full, q_pop, q_empty;
  sawa_pkg::entry_t                  push_entry, head;
  sawa_pkg::res_t                    res;
  logic [sawa_pkg::QCNT_W-1:0]       q_count;
  logic                              sec_pending;

  assign cfg_ready_o     = 1'b1;
  assign cfg             = {cfg_valid_i, cfg_index_i, cfg_data_i};
  assign s_axis_tready_o = !q_full;

  sawa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .valid_i      (s_axis_tvalid_i),
    .accept_i     (s_axis_tready_o),
    .kind_i       (sawa_pkg::kind_e'(s_axis_tuser_i)),
    .own_port_i   (s_axis_tdata_i[15:0]),
    .rx_port_i    (s_axis_tdata_i[31:16]),
    .push_o       (q_push),
    .entry_o      (push_entry)
  );

  sawa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  sawa_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .ready_i       (m_axis_tready_i),
    .valid_o       (m_axis_tvalid_o),
    .res_o         (res),
    .last_o        (m_axis_tlast_o),
    .sec_pending_o (sec_pending)
  );

  assign m_axis_tdata_o = {7'd0, res.seq, res.peer, res.tx};
  assign m_axis_tuser_o = res.ev;

  `SAW_ASSERT(a_q_bound, clk_i, rst_ni, q_count <= sawa_pkg::QCNT_W'(sawa_pkg::QDEPTH), "queue count out of range")
  `SAW_ASSERT(a_sec_hold, clk_i, rst_ni, sec_pending |-> (m_axis_tvalid_o && !m_axis_tlast_o), "second result pending without first shown")
  `SAW_ASSERT(a_deliver_first, clk_i, rst_ni, (m_axis_tvalid_o && !m_axis_tlast_o) |-> (res.ev == sawa_pkg::EV_DELIVER), "non-final result is not a deliver")
  `SAW_ASSERT(a_ready_full, clk_i, rst_ni, !s_axis_tready_o |-> (q_count == sawa_pkg::QCNT_W'(sawa_pkg::QDEPTH) && m_axis_tvalid_o), "input stalled with room left")

endmodule

/* dv/stop_and_wait_arq_endpoint_checker.sv */
// Scoreboard for the ARQ endpoint: tracks protocol state from accepted words and checks results.
module stop_and_wait_arq_endpoint_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  // [15:0] own_port, [31:16] rx_port
  input  logic [sawa_pkg::TDATA_IN_W-1:0]  s_tdata_i,
  // [1:0] kind
  input  logic [1:0]                       s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  // [15:0] tx_port, [31:16] peer_port, [32] seq_bit, [39:33] zero
  input  logic [sawa_pkg::TDATA_OUT_W-1:0] m_tdata_i,
  // [2:0] event_res
  input  logic [2:0]                       m_tuser_i,
  input  logic                             m_tlast_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [1:0]                       cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    sawa_pkg::event_e ev;
    logic [15:0]      tx;
    logic [15:0]      peer;
    logic             seq;
    logic             last;
  } outcome_t;

  outcome_t due_results[$];

  logic [31:0]                      timeout_ticks;
  logic [15:0]                      port_mask;
  logic [15:0]                      fallback;
  logic                             waiting;
  logic                             tx_seq;
  logic                             rx_seq;
  logic                             timer_on;
  logic [15:0]                      held_port;
  logic [sawa_pkg::TIMER_WIDTH-1:0] timer_cnt;

  task automatic flag_mismatch(string msg);
    errors_o++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %h want %h", results_o, name, got, want));
  endtask

  task automatic queue_result(sawa_pkg::event_e ev, logic [15:0] tx, logic [15:0] peer,
                              logic seq, logic last);
    outcome_t o;
    o.ev   = ev;
    o.tx   = tx;
    o.peer = peer;
    o.seq  = seq;
    o.last = last;
    due_results.push_back(o);
  endtask

  task automatic apply_event(sawa_pkg::kind_e kind, logic [15:0] lport, logic [15:0] rport);
    logic [15:0] port;
    logic [15:0] peer;
    logic        s;
    peer = {rport[15:2], 2'b00};
    s    = rport[1];
    case (kind)
      sawa_pkg::KIND_SEND: begin
        if (waiting) begin
          queue_result(sawa_pkg::EV_REFUSED, 16'h0, 16'h0, ~tx_seq, 1'b1);
        end else begin
          port      = ((lport & port_mask) != 16'h0) ? fallback : lport;
          held_port = port;
          queue_result(sawa_pkg::EV_SENT, port + {tx_seq, 1'b0}, 16'h0, tx_seq, 1'b1);
          tx_seq    = ~tx_seq;
          waiting   = 1'b1;
          timer_on  = 1'b1;
          timer_cnt = '0;
        end
      end
      sawa_pkg::KIND_RX: begin
        if (rport[0]) begin
          // stale acks are dropped silently
          if (s == ~tx_seq) begin
            waiting   = 1'b0;
            timer_on  = 1'b0;
            timer_cnt = '0;
            queue_result(sawa_pkg::EV_ACK_TAKEN, 16'h0, peer, s, 1'b1);
          end
        end else begin
          if (s == rx_seq) begin
            rx_seq = ~s;
            queue_result(sawa_pkg::EV_DELIVER, 16'h0, peer, s, 1'b0);
          end
          queue_result(sawa_pkg::EV_ACK_SENT, lport + 16'd1 + {s, 1'b0}, peer, s, 1'b1);
        end
      end
      sawa_pkg::KIND_TICK: begin
        if (timer_on) begin
          if (timer_cnt != '1) timer_cnt++;
          if (timer_cnt >= timeout_ticks) begin
            timer_cnt = '0;
            queue_result(sawa_pkg::EV_RESENT, held_port + {~tx_seq, 1'b0}, 16'h0, ~tx_seq,
                         1'b1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    outcome_t want;
    results_o++;
    if (due_results.size() == 0) begin
      flag_mismatch($sformatf("result %0d unexpected: event %0d data %h last %b",
                              results_o, m_tuser_i, m_tdata_i, m_tlast_i));
      return;
    end
    want = due_results.pop_front();
    check_field("event", {13'h0, m_tuser_i}, {13'h0, want.ev});
    check_field("tx_port", m_tdata_i[15:0], want.tx);
    check_field("peer_port", m_tdata_i[31:16], want.peer);
    check_field("seq_bit", {15'h0, m_tdata_i[32]}, {15'h0, want.seq});
    check_field("last", {15'h0, m_tlast_i}, {15'h0, want.last});
    check_field("padding", {9'h0, m_tdata_i[39:33]}, 16'h0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks = sawa_pkg::TIMEOUT_RESET;
      port_mask     = sawa_pkg::MASK_RESET;
      fallback      = sawa_pkg::FALLBACK_RESET;
      waiting       = 1'b0;
      tx_seq        = 1'b0;
      rx_seq        = 1'b0;
      timer_on      = 1'b0;
      held_port     = 16'h0;
      timer_cnt     = '0;
      due_results.delete();
      pending_o     = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        case (sawa_pkg::reg_e'(cfg_index_i))
          sawa_pkg::REG_TIMEOUT:  timeout_ticks = cfg_data_i;
          sawa_pkg::REG_MASK:     port_mask     = cfg_data_i[15:0];
          sawa_pkg::REG_FALLBACK: fallback      = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        apply_event(sawa_pkg::kind_e'(s_tuser_i), s_tdata_i[15:0], s_tdata_i[31:16]);
      pending_o = due_results.size();
    end
  end

endmodule

/* dv/stop_and_wait_arq_endpoint_test.sv */
// Testbench top for the ARQ endpoint: clock, reset, event and register stimulus, verdict.
module stop_and_wait_arq_endpoint_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT  = 200000;
  localparam int PHASES = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  int          errors;
  int          pending;
  int          results;
  int          words_sent;
  int          cycles;
  int          send_idle;
  int          recv_stall;
  logic [15:0] cur_mask;

  logic [31:0] timeout_tab [PHASES] = '{32'd1, 32'd3, 32'hFFFF_FFFF, 32'd2,
                                        32'd1000, 32'd5, 32'd1, 32'd4};
  logic [15:0] mask_tab [PHASES]    = '{16'h0000, 16'hFFFF, 16'h8001, 16'h00F0,
                                        16'h0000, 16'h7FFE, 16'h0003, 16'h1000};
  logic [15:0] fallback_tab [PHASES] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFE,
                                         16'd5012, 16'h0003, 16'hABCD, 16'h8000};

  stop_and_wait_arq_endpoint uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  stop_and_wait_arq_endpoint_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall);
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic put_word(sawa_pkg::kind_e kind, logic [15:0] lport, logic [15:0] rport);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {rport, lport};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(sawa_pkg::reg_e idx, logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFC | 16'($urandom_range(3));
      3, 4:    return 16'($urandom) & ~cur_mask;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_word();
    int              pick;
    sawa_pkg::kind_e kind;
    logic [15:0]     lport;
    logic [15:0]     rport;
    pick  = $urandom_range(99);
    lport = pick_port();
    rport = 16'($urandom);
    if (pick < 28)      kind = sawa_pkg::KIND_SEND;
    else if (pick < 68) kind = sawa_pkg::KIND_RX;
    else if (pick < 96) kind = sawa_pkg::KIND_TICK;
    else                kind = sawa_pkg::KIND_NONE;
    put_word(kind, lport, rport);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle     = 0;
    recv_stall    = 0;
    cur_mask      = sawa_pkg::MASK_RESET;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: timeout 1000, no mask
    put_word(sawa_pkg::KIND_TICK, 16'h0000, 16'h0000);
    put_word(sawa_pkg::KIND_NONE, 16'hFFFF, 16'hFFFF);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'hABC1);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'hFFFF);
    put_word(sawa_pkg::KIND_RX,   16'hFFFF, 16'hFFFC);
    put_word(sawa_pkg::KIND_RX,   16'h1000, 16'h0000);
    put_word(sawa_pkg::KIND_RX,   16'hFFFE, 16'h0002);
    put_word(sawa_pkg::KIND_SEND, 16'hFFFF, 16'h0000);
    put_word(sawa_pkg::KIND_SEND, 16'h0001, 16'h0000);
    put_word(sawa_pkg::KIND_TICK, 16'h0000, 16'h0000);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'h0003);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'h0001);
    put_word(sawa_pkg::KIND_SEND, 16'hFFFE, 16'h0000);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'hFFFF);
    settle();
    write_reg(sawa_pkg::REG_TIMEOUT, 32'd1);
    write_reg(sawa_pkg::REG_MASK, 32'h0000_8001);
    write_reg(sawa_pkg::REG_FALLBACK, 32'h0000_FFFF);
    cur_mask = 16'h8001;
    put_word(sawa_pkg::KIND_SEND, 16'h8000, 16'h0000);
    put_word(sawa_pkg::KIND_TICK, 16'h0000, 16'h0000);
    put_word(sawa_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'h0001);
    put_word(sawa_pkg::KIND_TICK, 16'h0000, 16'h0000);
    put_word(sawa_pkg::KIND_SEND, 16'h1234, 16'h0000);
    put_word(sawa_pkg::KIND_RX,   16'h0000, 16'h0003);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(sawa_pkg::REG_TIMEOUT, timeout_tab[ph]);
      write_reg(sawa_pkg::REG_MASK, {16'h0, mask_tab[ph]});
      write_reg(sawa_pkg::REG_FALLBACK, {16'h0, fallback_tab[ph]});
      cur_mask = mask_tab[ph];
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      for (int n = 0; n < 88; n++) begin
        if ($urandom_range(49) == 0) settle();
        random_word();
      end
    end

    settle();
    $display("%0d event words across %0d register settings plus the reset one", words_sent,
             PHASES + 1);
    $display("%0d results checked, %0d mismatches", results, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
